// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/kli_pkg.sv =====
package kli_pkg;

  localparam int MaxKnots = 64;
  localparam int IdxW     = $clog2(MaxKnots);
  localparam int CntW     = IdxW + 1;
  localparam int MassW    = 16;
  localparam int CoefW    = 16;
  localparam int DivW     = 32;
  localparam int DivCntW  = $clog2(DivW);
  localparam int SumW     = DivW + 2;

  localparam logic [CntW-1:0] KnotsReset = CntW'(MaxKnots);
  localparam logic [CntW-1:0] KnotsMin   = CntW'(2);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;

  typedef struct packed {
    op_e                     operation;
    logic [IdxW-1:0]         knot_index;
    logic [MassW-1:0]        knot_mass;
    logic signed [CoefW-1:0] knot_real;
    logic signed [CoefW-1:0] knot_imag;
    logic [MassW-1:0]        query_mass;
  } in_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0] amp_real;
    logic signed [CoefW-1:0] amp_imag;
    logic [1:0]              range_status;
  } out_word_t;

  typedef struct packed {
    logic [MassW-1:0]        mass;
    logic signed [CoefW-1:0] re;
    logic signed [CoefW-1:0] im;
  } knot_t;

  localparam int KnotW = $bits(knot_t);

  typedef struct packed {
    logic     valid;
    logic     is_eval;
    in_word_t word;
  } q_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_PREP,
    BK_DIV,
    BK_FIN,
    BK_EMIT
  } back_state_e;

  function automatic logic signed [CoefW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32767);
    lo = -SumW'(32768);
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[CoefW-1:0];
  endfunction

endpackage

// ===== rtl/kli_ram.sv =====
module kli_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/kli_front.sv =====
module kli_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kli_pkg::in_word_t in_word_i,
  output kli_pkg::q_head_t  head_o,
  input  logic              pop_i
);
  import kli_pkg::*;

  in_word_t   buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != 2'd0);

  assign head_o.valid   = (count_q != 2'd0);
  assign head_o.word    = buf_q[rd_ptr_q];
  assign head_o.is_eval = (buf_q[rd_ptr_q].operation == OP_EVAL);

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_word_i;
    end
  end

endmodule

// ===== rtl/kli_back.sv =====
module kli_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kli_pkg::q_head_t           head_i,
  output logic                       pop_o,
  input  logic                       cfg_we_i,
  input  logic [kli_pkg::CntW-1:0]   cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kli_pkg::out_word_t         out_word_o
);
  import kli_pkg::*;

  back_state_e state_q, state_d;

  logic [CntW-1:0]     knots_q;
  logic [MaxKnots-1:0] written_q, written_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [MassW-1:0]    qm_q, qm_d;
  knot_t               prev_q, prev_d;
  logic [MassW-1:0]    span_q, span_d;
  logic [MassW-1:0]    above_q, above_d;

  logic signed [CoefW:0]   diff_q [2];
  logic signed [CoefW:0]   diff_d [2];
  logic signed [CoefW-1:0] chi_q  [2];
  logic signed [CoefW-1:0] chi_d  [2];
  logic signed [SumW-1:0]  prod_q [2];
  logic signed [SumW-1:0]  prod_d [2];
  logic                    neg_q  [2];
  logic                    neg_d  [2];
  logic [DivW-1:0]         dvd_q  [2];
  logic [DivW-1:0]         dvd_d  [2];
  logic [MassW-1:0]        rem_q  [2];
  logic [MassW-1:0]        rem_d  [2];

  out_word_t res_q, res_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  knot_t           ram_wdata;
  knot_t           rd;

  logic [CntW-1:0]     n_eff;
  logic [CntW-1:0]     last_w;
  logic [IdxW-1:0]     last_idx;
  logic [MaxKnots-1:0] below;
  logic                loaded;
  logic                out_free;

  logic signed [CoefW-1:0] rd_c   [2];
  logic signed [CoefW-1:0] prev_c [2];

  kli_ram #(
    .Width (KnotW),
    .Depth (MaxKnots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.word.knot_index),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  assign ram_wdata = '{mass: head_i.word.knot_mass, re: head_i.word.knot_real,
                       im: head_i.word.knot_imag};
  assign rd_c[0]   = rd.re;
  assign rd_c[1]   = rd.im;
  assign prev_c[0] = prev_q.re;
  assign prev_c[1] = prev_q.im;

  always_comb begin
    n_eff = knots_q;
    if (knots_q < KnotsMin) begin
      n_eff = KnotsMin;
    end else if (knots_q > CntW'(MaxKnots)) begin
      n_eff = CntW'(MaxKnots);
    end
    last_w   = n_eff - CntW'(1);
    last_idx = last_w[IdxW-1:0];
    for (int i = 0; i < MaxKnots; i++) begin
      below[i] = (CntW'(i) < n_eff);
    end
    loaded = &(written_q | ~below);
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    logic [MassW:0]         t;
    logic signed [SumW-1:0] sum;
    logic [SumW-1:0]        mag;
    state_d     = state_q;
    written_d   = written_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    qm_d        = qm_q;
    prev_d      = prev_q;
    span_d      = span_q;
    above_d     = above_q;
    diff_d      = diff_q;
    chi_d       = chi_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = idx_q + IdxW'(1);
    t           = '0;
    sum         = '0;
    mag         = '0;

    unique case (state_q)
      BK_IDLE: begin
        ram_raddr = '0;
        if (head_i.valid) begin
          pop_o = 1'b1;
          qm_d  = head_i.word.query_mass;
          if (!head_i.is_eval) begin
            ram_we                           = 1'b1;
            written_d[head_i.word.knot_index] = 1'b1;
          end else if (loaded) begin
            idx_d   = '0;
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        prev_d = rd;
        if (qm_q >= rd.mass) begin
          if (idx_q == last_idx) begin
            res_d   = '{amp_real: rd.re, amp_imag: rd.im, range_status: ST_ABOVE};
            state_d = BK_EMIT;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else if (idx_q == '0) begin
          res_d   = '{amp_real: rd.re, amp_imag: rd.im, range_status: ST_BELOW};
          state_d = BK_EMIT;
        end else if (rd.mass <= prev_q.mass) begin
          res_d   = '{amp_real: prev_q.re, amp_imag: prev_q.im, range_status: ST_INSIDE};
          state_d = BK_EMIT;
        end else begin
          span_d  = rd.mass - prev_q.mass;
          above_d = rd.mass - qm_q;
          for (int c = 0; c < 2; c++) begin
            diff_d[c] = {prev_c[c][CoefW-1], prev_c[c]} - {rd_c[c][CoefW-1], rd_c[c]};
            chi_d[c]  = rd_c[c];
          end
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        for (int c = 0; c < 2; c++) begin
          prod_d[c] = SumW'($signed({1'b0, above_q}) * diff_q[c]);
        end
        state_d = BK_PREP;
      end
      BK_PREP: begin
        for (int c = 0; c < 2; c++) begin
          neg_d[c] = prod_q[c][SumW-1];
          mag      = neg_d[c] ? SumW'(-prod_q[c]) : SumW'(prod_q[c]);
          mag      = mag + SumW'(span_q >> 1);
          dvd_d[c] = mag[DivW-1:0];
          rem_d[c] = '0;
        end
        cnt_d   = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        for (int c = 0; c < 2; c++) begin
          t = {rem_q[c], dvd_q[c][DivW-1]};
          if (t >= {1'b0, span_q}) begin
            t        = t - {1'b0, span_q};
            dvd_d[c] = {dvd_q[c][DivW-2:0], 1'b1};
          end else begin
            dvd_d[c] = {dvd_q[c][DivW-2:0], 1'b0};
          end
          rem_d[c] = t[MassW-1:0];
        end
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivW - 1)) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        for (int c = 0; c < 2; c++) begin
          sum = neg_q[c] ? -$signed({2'b00, dvd_q[c]}) : $signed({2'b00, dvd_q[c]});
          sum = sum + SumW'(chi_q[c]);
          if (c == 0) begin
            res_d.amp_real = sat16(sum);
          end else begin
            res_d.amp_imag = sat16(sum);
          end
        end
        res_d.range_status = ST_INSIDE;
        state_d            = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      knots_q     <= KnotsReset;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        knots_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    qm_q    <= qm_d;
    prev_q  <= prev_d;
    span_q  <= span_d;
    above_q <= above_d;
    diff_q  <= diff_d;
    chi_q   <= chi_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/knot_table_linear_interp_unit.sv =====
// Knot table interpolator.
// Input channel in_valid_i / in_stall_o carries one word: operation 0 loads
// knot_index with mass and complex coefficient, operation 1 evaluates
// query_mass. Output channel out_valid_o / out_stall_i returns one word per
// evaluation once every slot below knots_used has been loaded; loads and
// evaluations of an incomplete table give no word.
// knots_used is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, as the block does not enforce this. A two-word queue sits
// between the input side and the evaluator, so input is taken while the
// evaluator works or a result waits. A load is written to the knot memory
// straight from the evaluator's idle state. An evaluation scans the knot
// memory linearly up to the first knot above the query, then, when it lands
// inside the table, runs a multiply, a 32-step restoring divide and
// saturation; its result then goes into the output register.
// Reset clears the queue, the loaded flags and the output; knots_used
// returns to 64. The knot memory keeps its contents.
// A stalled output holds its word; the evaluator then waits with its result
// and the queue fills, raising in_stall_o.
module knot_table_linear_interp_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  kli_pkg::in_word_t        in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output kli_pkg::out_word_t       out_word_o,
  input  logic                     cfg_we_i,
  input  logic [kli_pkg::CntW-1:0] cfg_wdata_i
);
  import kli_pkg::*;

  q_head_t head;
  logic    pop;

  kli_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  kli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/kli_checker.sv =====
`include "assert_macros.svh"

module kli_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input kli_pkg::out_word_t out_word_o
);
  import kli_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_word_o))
  `ASSERT_IMPLY(a_status_code, clk_i, rst_ni, out_valid_o, out_word_o.range_status != 2'd3)
  `ASSERT_IMPLY(a_full_after_push, clk_i, rst_ni, $rose(in_stall_o),
                $past(in_valid_i && !in_stall_o))

endmodule

bind knot_table_linear_interp_unit kli_checker u_kli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
